// ===== hdl/rvcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rvcsr_pkg
// Shared types, CSR numbers and field masks for the RV32 M/S CSR file.
// ----------------------------------------------------------------------------
package rvcsr_pkg;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] PRV_U = 2'd0;
	localparam logic [1:0] PRV_S = 2'd1;
	localparam logic [1:0] PRV_M = 2'd3;

	localparam logic [11:0] ADR_SSTATUS    = 12'h100;
	localparam logic [11:0] ADR_SIE        = 12'h104;
	localparam logic [11:0] ADR_STVEC      = 12'h105;
	localparam logic [11:0] ADR_SCOUNTEREN = 12'h106;
	localparam logic [11:0] ADR_SSCRATCH   = 12'h140;
	localparam logic [11:0] ADR_SEPC       = 12'h141;
	localparam logic [11:0] ADR_SCAUSE     = 12'h142;
	localparam logic [11:0] ADR_STVAL      = 12'h143;
	localparam logic [11:0] ADR_SIP        = 12'h144;
	localparam logic [11:0] ADR_STIMECMP   = 12'h14D;
	localparam logic [11:0] ADR_STIMECMPH  = 12'h15D;
	localparam logic [11:0] ADR_SATP       = 12'h180;
	localparam logic [11:0] ADR_MSTATUS    = 12'h300;
	localparam logic [11:0] ADR_MISA       = 12'h301;
	localparam logic [11:0] ADR_MEDELEG    = 12'h302;
	localparam logic [11:0] ADR_MIDELEG    = 12'h303;
	localparam logic [11:0] ADR_MIE        = 12'h304;
	localparam logic [11:0] ADR_MTVEC      = 12'h305;
	localparam logic [11:0] ADR_MCOUNTEREN = 12'h306;
	localparam logic [11:0] ADR_MENVCFG    = 12'h30A;
	localparam logic [11:0] ADR_MSTATUSH   = 12'h310;
	localparam logic [11:0] ADR_MENVCFGH   = 12'h31A;
	localparam logic [11:0] ADR_MCOUNTINH  = 12'h320;
	localparam logic [11:0] ADR_MSCRATCH   = 12'h340;
	localparam logic [11:0] ADR_MEPC       = 12'h341;
	localparam logic [11:0] ADR_MCAUSE     = 12'h342;
	localparam logic [11:0] ADR_MTVAL      = 12'h343;
	localparam logic [11:0] ADR_MIP        = 12'h344;
	localparam logic [11:0] ADR_MCYCLE     = 12'hB00;
	localparam logic [11:0] ADR_MINSTRET   = 12'hB02;
	localparam logic [11:0] ADR_MCYCLEH    = 12'hB80;
	localparam logic [11:0] ADR_MINSTRETH  = 12'hB82;
	localparam logic [11:0] ADR_CYCLE      = 12'hC00;
	localparam logic [11:0] ADR_TIME       = 12'hC01;
	localparam logic [11:0] ADR_INSTRET    = 12'hC02;
	localparam logic [11:0] ADR_CYCLEH     = 12'hC80;
	localparam logic [11:0] ADR_TIMEH      = 12'hC81;
	localparam logic [11:0] ADR_INSTRETH   = 12'hC82;
	localparam logic [11:0] ADR_MVENDORID  = 12'hF11;
	localparam logic [11:0] ADR_MARCHID    = 12'hF12;
	localparam logic [11:0] ADR_MIMPID     = 12'hF13;
	localparam logic [11:0] ADR_MHARTID    = 12'hF14;
	localparam logic [11:0] ADR_MCONFIGPTR = 12'hF15;

	localparam logic [31:0] ST_SIE  = 32'h0000_0002;
	localparam logic [31:0] ST_MIE  = 32'h0000_0008;
	localparam logic [31:0] ST_SPIE = 32'h0000_0020;
	localparam logic [31:0] ST_MPIE = 32'h0000_0080;
	localparam logic [31:0] ST_SPP  = 32'h0000_0100;
	localparam logic [31:0] ST_MPP  = 32'h0000_1800;
	localparam logic [31:0] ST_FS   = 32'h0000_6000;
	localparam logic [31:0] ST_MPRV = 32'h0002_0000;
	localparam logic [31:0] ST_SUM  = 32'h0004_0000;
	localparam logic [31:0] ST_MXR  = 32'h0008_0000;
	localparam logic [31:0] ST_TVM  = 32'h0010_0000;
	localparam logic [31:0] ST_TW   = 32'h0020_0000;
	localparam logic [31:0] ST_TSR  = 32'h0040_0000;
	localparam logic [31:0] ST_SD   = 32'h8000_0000;
	localparam logic [31:0] S_VIEW  = ST_SIE | ST_SPIE | ST_SPP | ST_FS | ST_SUM | ST_MXR | ST_SD;
	localparam logic [31:0] S_WR    = S_VIEW & ~ST_SD;
	localparam logic [31:0] M_WR    = S_WR | ST_MIE | ST_MPIE | ST_MPP | ST_MPRV | ST_TVM
		| ST_TW | ST_TSR;

	localparam logic [31:0] IE_MASK        = 32'h0000_02AA;
	localparam logic [31:0] DELEG_INT_MASK = 32'h0000_0222;
	localparam logic [31:0] DELEG_EXC_MASK = 32'h0000_B3FF;
	localparam logic [2:0]  CEN_MASK       = 3'h7;
	localparam logic [2:0]  INHIBIT_MASK   = 3'h5;

	localparam logic [31:0] ISA_WORD    = 32'h4014_112D;
	localparam logic [31:0] VENDOR_WORD = 32'h7973_7978;
	localparam logic [31:0] ARCH_WORD   = 32'd26030082;

	typedef struct packed {
		logic        operation;
		logic [11:0] csr_address;
		logic [31:0] write_data;
		logic [1:0]  privilege;
		logic [31:0] pending_lines;
		logic [63:0] time_value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        illegal;
	} rsp_t;

endpackage

// ===== hdl/rvcsr_core.sv =====
// ----------------------------------------------------------------------------
// rvcsr_core
// CSR state, access check, read select and masked write update for one request.
// ----------------------------------------------------------------------------
module rvcsr_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           commit,
	input  rvcsr_pkg::req_t req,
	output rvcsr_pkg::rsp_t rsp
);
	import rvcsr_pkg::*;

	function automatic logic [31:0] fix_status(input logic [31:0] v);
		logic [31:0] r;
		r = v;
		if (r[12:11] == 2'd2) begin
			r[12:11] = 2'd0;
		end
		r[31] = (r[14:13] == 2'd3);
		return r;
	endfunction

	logic [31:0] status_q, ie_q, ideleg_q, edeleg_q;
	logic [31:0] mtvec_q, stvec_q, mepc_q, sepc_q, mcause_q, scause_q;
	logic [31:0] mtval_q, stval_q, mscratch_q, sscratch_q, satp_q;
	logic [2:0]  mcen_q, scen_q, inhibit_q;
	logic        stce_q, ssip_q;
	logic [63:0] stimecmp_q, cycle_q, instret_q;

	logic [31:0] status_d, ie_d, ideleg_d, edeleg_d;
	logic [31:0] mtvec_d, stvec_d, mepc_d, sepc_d, mcause_d, scause_d;
	logic [31:0] mtval_d, stval_d, mscratch_d, sscratch_d, satp_d;
	logic [2:0]  mcen_d, scen_d, inhibit_d;
	logic        stce_d, ssip_d;
	logic [63:0] stimecmp_d, cycle_d, instret_d;

	logic [11:0] a;
	logic [31:0] d;
	logic [1:0]  p;
	logic        is_wr;
	logic [2:0]  ctr_hit, ctr_en;
	logic        acc_ok, rd_hit, wr_hit, ok;
	logic [31:0] rd_val, mip;

	assign a     = req.csr_address;
	assign d     = req.write_data;
	assign p     = req.privilege;
	assign is_wr = (req.operation == OP_WRITE);

	assign ctr_hit[0] = (a == ADR_CYCLE)   || (a == ADR_CYCLEH);
	assign ctr_hit[1] = (a == ADR_TIME)    || (a == ADR_TIMEH);
	assign ctr_hit[2] = (a == ADR_INSTRET) || (a == ADR_INSTRETH);

	always_comb begin
		unique case (p)
			PRV_M:   ctr_en = 3'b111;
			PRV_S:   ctr_en = mcen_q;
			PRV_U:   ctr_en = mcen_q & scen_q;
			default: ctr_en = 3'b000;
		endcase
	end

	always_comb begin
		acc_ok = 1'b1;
		if (p < a[9:8]) begin
			acc_ok = 1'b0;
		end
		if (a == ADR_SATP && p == PRV_S && status_q[20]) begin
			acc_ok = 1'b0;
		end
		if (is_wr && a[11:10] == 2'b11) begin
			acc_ok = 1'b0;
		end
		if ((|ctr_hit) && !(|(ctr_hit & ctr_en))) begin
			acc_ok = 1'b0;
		end
		if ((a == ADR_STIMECMP || a == ADR_STIMECMPH) && p != PRV_M
				&& !(stce_q && mcen_q[1])) begin
			acc_ok = 1'b0;
		end
	end

	assign mip = {req.pending_lines[31:2], ssip_q, req.pending_lines[0]};

	always_comb begin
		rd_hit = 1'b1;
		rd_val = '0;
		unique case (a) inside
			ADR_SSTATUS:    rd_val = status_q & S_VIEW;
			ADR_SIE:        rd_val = ie_q & ideleg_q;
			ADR_STVEC:      rd_val = stvec_q;
			ADR_SCOUNTEREN: rd_val = {29'd0, scen_q};
			ADR_SSCRATCH:   rd_val = sscratch_q;
			ADR_SEPC:       rd_val = sepc_q;
			ADR_SCAUSE:     rd_val = scause_q;
			ADR_STVAL:      rd_val = stval_q;
			ADR_SIP:        rd_val = mip & ideleg_q;
			ADR_STIMECMP:   rd_val = stimecmp_q[31:0];
			ADR_STIMECMPH:  rd_val = stimecmp_q[63:32];
			ADR_SATP:       rd_val = satp_q;
			ADR_MSTATUS:    rd_val = status_q;
			ADR_MISA:       rd_val = ISA_WORD;
			ADR_MEDELEG:    rd_val = edeleg_q;
			ADR_MIDELEG:    rd_val = ideleg_q;
			ADR_MIE:        rd_val = ie_q;
			ADR_MTVEC:      rd_val = mtvec_q;
			ADR_MCOUNTEREN: rd_val = {29'd0, mcen_q};
			ADR_MENVCFG, ADR_MSTATUSH: rd_val = '0;
			ADR_MENVCFGH:   rd_val = {stce_q, 31'd0};
			ADR_MCOUNTINH:  rd_val = {29'd0, inhibit_q};
			ADR_MSCRATCH:   rd_val = mscratch_q;
			ADR_MEPC:       rd_val = mepc_q;
			ADR_MCAUSE:     rd_val = mcause_q;
			ADR_MTVAL:      rd_val = mtval_q;
			ADR_MIP:        rd_val = mip;
			ADR_TIME:       rd_val = req.time_value[31:0];
			ADR_TIMEH:      rd_val = req.time_value[63:32];
			ADR_MCYCLE, ADR_CYCLE:       rd_val = cycle_q[31:0];
			ADR_MCYCLEH, ADR_CYCLEH:     rd_val = cycle_q[63:32];
			ADR_MINSTRET, ADR_INSTRET:   rd_val = instret_q[31:0];
			ADR_MINSTRETH, ADR_INSTRETH: rd_val = instret_q[63:32];
			ADR_MVENDORID:  rd_val = VENDOR_WORD;
			ADR_MARCHID:    rd_val = ARCH_WORD;
			ADR_MIMPID, ADR_MHARTID, ADR_MCONFIGPTR: rd_val = '0;
			default:        rd_hit = 1'b0;
		endcase
	end

	always_comb begin
		status_d   = status_q;
		ie_d       = ie_q;
		ideleg_d   = ideleg_q;
		edeleg_d   = edeleg_q;
		mtvec_d    = mtvec_q;
		stvec_d    = stvec_q;
		mepc_d     = mepc_q;
		sepc_d     = sepc_q;
		mcause_d   = mcause_q;
		scause_d   = scause_q;
		mtval_d    = mtval_q;
		stval_d    = stval_q;
		mscratch_d = mscratch_q;
		sscratch_d = sscratch_q;
		satp_d     = satp_q;
		mcen_d     = mcen_q;
		scen_d     = scen_q;
		inhibit_d  = inhibit_q;
		stce_d     = stce_q;
		ssip_d     = ssip_q;
		stimecmp_d = stimecmp_q;
		cycle_d    = cycle_q;
		instret_d  = instret_q;
		wr_hit     = 1'b1;
		unique case (a)
			ADR_SSTATUS:    status_d = fix_status((status_q & ~S_WR) | (d & S_WR));
			ADR_SIE:        ie_d = (ie_q & ~ideleg_q) | (d & ideleg_q & IE_MASK);
			ADR_STVEC:      stvec_d = d & ~32'd2;
			ADR_SCOUNTEREN: scen_d = d[2:0] & CEN_MASK;
			ADR_SSCRATCH:   sscratch_d = d;
			ADR_SEPC:       sepc_d = d & ~32'd1;
			ADR_SCAUSE:     scause_d = d;
			ADR_STVAL:      stval_d = d;
			ADR_SIP: begin
				if (ideleg_q[1]) begin
					ssip_d = d[1];
				end
			end
			ADR_STIMECMP:   stimecmp_d = {stimecmp_q[63:32], d};
			ADR_STIMECMPH:  stimecmp_d = {d, stimecmp_q[31:0]};
			ADR_SATP:       satp_d = d;
			ADR_MSTATUS:    status_d = fix_status(d & M_WR);
			ADR_MISA:       ;
			ADR_MEDELEG:    edeleg_d = d & DELEG_EXC_MASK;
			ADR_MIDELEG:    ideleg_d = d & DELEG_INT_MASK;
			ADR_MIE:        ie_d = d & IE_MASK;
			ADR_MTVEC:      mtvec_d = d & ~32'd2;
			ADR_MCOUNTEREN: mcen_d = d[2:0] & CEN_MASK;
			ADR_MENVCFG:    ;
			ADR_MENVCFGH:   stce_d = d[31];
			ADR_MCOUNTINH:  inhibit_d = d[2:0] & INHIBIT_MASK;
			ADR_MSCRATCH:   mscratch_d = d;
			ADR_MEPC:       mepc_d = d & ~32'd1;
			ADR_MCAUSE:     mcause_d = d;
			ADR_MTVAL:      mtval_d = d;
			ADR_MIP:        ssip_d = d[1];
			ADR_MCYCLE:     cycle_d = {cycle_q[63:32], d};
			ADR_MCYCLEH:    cycle_d = {d, cycle_q[31:0]};
			ADR_MINSTRET:   instret_d = {instret_q[63:32], d};
			ADR_MINSTRETH:  instret_d = {d, instret_q[31:0]};
			default:        wr_hit = 1'b0;
		endcase
	end

	assign ok            = acc_ok && (is_wr ? wr_hit : rd_hit);
	assign rsp.illegal   = !ok;
	assign rsp.read_data = (ok && !is_wr) ? rd_val : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q   <= '0;
			ie_q       <= '0;
			ideleg_q   <= '0;
			edeleg_q   <= '0;
			mtvec_q    <= '0;
			stvec_q    <= '0;
			mepc_q     <= '0;
			sepc_q     <= '0;
			mcause_q   <= '0;
			scause_q   <= '0;
			mtval_q    <= '0;
			stval_q    <= '0;
			mscratch_q <= '0;
			sscratch_q <= '0;
			satp_q     <= '0;
			mcen_q     <= '0;
			scen_q     <= '0;
			inhibit_q  <= '0;
			stce_q     <= 1'b0;
			ssip_q     <= 1'b0;
			stimecmp_q <= '0;
			cycle_q    <= '0;
			instret_q  <= '0;
		end else if (commit && acc_ok && is_wr) begin
			status_q   <= status_d;
			ie_q       <= ie_d;
			ideleg_q   <= ideleg_d;
			edeleg_q   <= edeleg_d;
			mtvec_q    <= mtvec_d;
			stvec_q    <= stvec_d;
			mepc_q     <= mepc_d;
			sepc_q     <= sepc_d;
			mcause_q   <= mcause_d;
			scause_q   <= scause_d;
			mtval_q    <= mtval_d;
			stval_q    <= stval_d;
			mscratch_q <= mscratch_d;
			sscratch_q <= sscratch_d;
			satp_q     <= satp_d;
			mcen_q     <= mcen_d;
			scen_q     <= scen_d;
			inhibit_q  <= inhibit_d;
			stce_q     <= stce_d;
			ssip_q     <= ssip_d;
			stimecmp_q <= stimecmp_d;
			cycle_q    <= cycle_d;
			instret_q  <= instret_d;
		end
	end

	a_ro_write_illegal: assert property (@(posedge clk) disable iff (!arst_n)
		(is_wr && a[11:10] == 2'b11) |-> rsp.illegal)
		else $error("write to read-only CSR space not flagged");

	a_sd_tracks_fs: assert property (@(posedge clk) disable iff (!arst_n)
		status_q[31] == (status_q[14:13] == 2'd3))
		else $error("mstatus.SD out of step with FS");

	a_mpp_legal: assert property (@(posedge clk) disable iff (!arst_n)
		status_q[12:11] != 2'd2)
		else $error("mstatus.MPP holds reserved value");

	a_no_update_illegal: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && rsp.illegal) |=> $stable(status_q) && $stable(satp_q))
		else $error("illegal access changed state");

endmodule

// ===== hdl/rv32_privileged_csr_file_top.sv =====
// ----------------------------------------------------------------------------
// rv32_privileged_csr_file_top
// RV32 machine/supervisor CSR file with stream request and response channels.
// ----------------------------------------------------------------------------
// Each request is one CSR read or write and yields exactly one response. The
// block takes one request per cycle unless the response side stalls; each
// request passes through the input register, then the result register, which
// drives m_axis_tvalid, and is held there while the response side
// stalls. The access check, read select and write masking all sit between
// the input register and the result register, and CSR state is updated as
// the request moves into the result register, so a request always sees the
// effect of every earlier write.
module rv32_privileged_csr_file_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [11:0] csr_address, [43:12] write_data, [45:44] privilege,
	// [77:46] pending_lines, [141:78] time_value, [143:142] zero
	input  logic [143:0] s_axis_tdata,
	// [0] operation
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] read_data
	output logic [31:0]  m_axis_tdata,
	// [0] illegal
	output logic [0:0]   m_axis_tuser
);
	import rvcsr_pkg::*;

	req_t        req_s1;
	logic        valid_s1;
	logic        valid_s2;
	logic [31:0] rdata_s2;
	logic        illegal_s2;
	logic        adv_s1;
	rsp_t        rsp;

	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1.operation     <= s_axis_tuser[0];
			req_s1.csr_address   <= s_axis_tdata[11:0];
			req_s1.write_data    <= s_axis_tdata[43:12];
			req_s1.privilege     <= s_axis_tdata[45:44];
			req_s1.pending_lines <= s_axis_tdata[77:46];
			req_s1.time_value    <= s_axis_tdata[141:78];
		end
	end

	rvcsr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (adv_s1),
		.req    (req_s1),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rdata_s2   <= rsp.read_data;
			illegal_s2 <= rsp.illegal;
		end
	end

	assign m_axis_tvalid   = valid_s2;
	assign m_axis_tdata    = rdata_s2;
	assign m_axis_tuser[0] = illegal_s2;

	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
		else $error("illegal response carries data");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty result register");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted request lost");

	a_adv_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("advanced request has no response");

endmodule
